>>> rtl/stsg_pkg.sv
// Shared types, constants and the sine table of the sine tone sample generator.
// Used by stsg_front, stsg_back and sine_tone_sample_generator.
// No dependencies.
`default_nettype none

package stsg_pkg;

  localparam int MAX_CHANNELS    = 8;
  localparam int SINE_TABLE_BITS = 10;
  localparam int QUARTER_BITS    = SINE_TABLE_BITS - 2;
  localparam int LUT_DEPTH       = 1 << QUARTER_BITS;

  localparam int RATE_W  = 18;
  localparam int FREQ_W  = 17;
  localparam int CHAN_W  = 4;
  localparam int CFG_W   = 18;
  localparam int IDX_W   = 3;
  localparam int PROD_W  = RATE_W + FREQ_W;
  localparam int CNT_W   = $clog2(PROD_W + 1);
  localparam int MAG_W   = 16;
  localparam int WORD_W  = 16;
  localparam int CHCNT_W = $clog2(MAX_CHANNELS + 1);

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_SAMPLE_RATE      = 3'd0;
  localparam logic [IDX_W-1:0] REG_TONE_FREQUENCY   = 3'd1;
  localparam logic [IDX_W-1:0] REG_CHANNEL_COUNT    = 3'd2;
  localparam logic [IDX_W-1:0] REG_WIDE_SAMPLES     = 3'd3;
  localparam logic [IDX_W-1:0] REG_UNSIGNED_SAMPLES = 3'd4;
  localparam logic [IDX_W-1:0] REG_BIG_ENDIAN       = 3'd5;

  typedef enum logic [1:0] {
    TICK_TONE         = 2'b00,
    TICK_TONE_RESTART = 2'b01,
    TICK_SILENT       = 2'b10,
    TICK_SILENT_CLEAR = 2'b11
  } tick_e;

  typedef struct packed {
    logic valid;
    tick_e kind;
  } tick_t;

  typedef struct packed {
    logic [RATE_W-1:0] rate;
    logic [FREQ_W-1:0] freq;
    logic [CHAN_W-1:0] chans;
    logic              wide;
    logic              unsig;
    logic              big;
  } cfg_t;

  typedef logic [MAG_W-1:0] lut_t [LUT_DEPTH];

  // Q15 magnitude of sin(pi/2 * u/65536), 9th order series in Q30
  function automatic logic [MAG_W-1:0] quarter_sine(input logic [16:0] u);
    logic [63:0] t;
    logic [63:0] t2;
    logic [63:0] v;
    logic [63:0] s;
    logic [63:0] m;
    t  = 64'(u) << 14;
    t2 = (t * t) >> 30;
    v  = 64'd172272;
    v  = 64'd5026995    - ((t2 * v) >> 30);
    v  = 64'd85569306   - ((t2 * v) >> 30);
    v  = 64'd693598925  - ((t2 * v) >> 30);
    v  = 64'd1686629713 - ((t2 * v) >> 30);
    s  = (t * v) >> 30;
    m  = (s + 64'd16384) >> 15;
    if (m > 64'd32768) m = 64'd32768;
    return m[MAG_W-1:0];
  endfunction

  function automatic lut_t build_lut();
    lut_t lut;
    for (int k = 0; k < LUT_DEPTH; k++) begin
      lut[k] = quarter_sine(17'(k << (16 - QUARTER_BITS)));
    end
    return lut;
  endfunction

  localparam lut_t SINE_LUT = build_lut();
  localparam logic [MAG_W-1:0] SINE_PEAK = quarter_sine(17'h10000);

endpackage

`default_nettype wire

>>> rtl/sine_tone_sample_generator.sv
// Sine tone sample generator: one tick transaction in, one formatted sample
// per channel out. Top level; depends on stsg_pkg, stsg_front and stsg_back.
//
// Usage: ticks enter on push/full with restart_i and silent_i; restart_i
// clears the sample index before the tick, silent_i gives level zero and
// keeps the index. Results leave on empty/pop, one per channel, each with the
// same sample_word_o; last_channel_o marks the final one of a tick.
// Registers are written through cfg_we_i/cfg_index_i/cfg_data_i while idle.
// A two-entry tick queue sits ahead of the engine, and the result register
// sits behind it, so ticks keep arriving while results wait to be popped.
// A tone tick runs the bit-serial divider for the index wrap, for
// frequency*index modulo rate and for the phase quotient, with take,
// multiply, lookup and format around it; a silent tick goes straight to
// format. Each tick then emits one result per channel, one per cycle
// while the receiver pops, and the engine takes no new tick until then.
// When the receiver stalls, the engine holds its sample and the queue fills;
// full rises once two ticks wait. Reset empties both queues, clears the
// index and loads the register defaults.
`default_nettype none

module sine_tone_sample_generator (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [stsg_pkg::IDX_W-1:0]         cfg_index_i,
  input  wire logic [stsg_pkg::CFG_W-1:0]         cfg_data_i,
  input  wire logic                               push,
  output logic                                    full,
  input  wire logic                               restart_i,
  input  wire logic                               silent_i,
  output logic                                    empty,
  input  wire logic                               pop,
  output logic [stsg_pkg::WORD_W-1:0]             sample_word_o,
  output logic                                    last_channel_o
);

  stsg_pkg::cfg_t  cfg_q, cfg_d;
  stsg_pkg::tick_t tick;
  logic            take;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        stsg_pkg::REG_SAMPLE_RATE:      cfg_d.rate  = cfg_data_i[stsg_pkg::RATE_W-1:0];
        stsg_pkg::REG_TONE_FREQUENCY:   cfg_d.freq  = cfg_data_i[stsg_pkg::FREQ_W-1:0];
        stsg_pkg::REG_CHANNEL_COUNT:    cfg_d.chans = cfg_data_i[stsg_pkg::CHAN_W-1:0];
        stsg_pkg::REG_WIDE_SAMPLES:     cfg_d.wide  = cfg_data_i[0];
        stsg_pkg::REG_UNSIGNED_SAMPLES: cfg_d.unsig = cfg_data_i[0];
        stsg_pkg::REG_BIG_ENDIAN:       cfg_d.big   = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rate  <= 18'd44100;
      cfg_q.freq  <= 17'd880;
      cfg_q.chans <= 4'd1;
      cfg_q.wide  <= 1'b1;
      cfg_q.unsig <= 1'b0;
      cfg_q.big   <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  stsg_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .restart_i (restart_i),
    .silent_i  (silent_i),
    .tick_o    (tick),
    .take_i    (take)
  );

  stsg_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .tick_i         (tick),
    .take_o         (take),
    .empty          (empty),
    .pop            (pop),
    .sample_word_o  (sample_word_o),
    .last_channel_o (last_channel_o)
  );

  // narrow samples leave the high byte clear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !cfg_q.wide) |-> (sample_word_o[15:8] == 8'd0))
    else $error("high byte set on 8-bit sample");

  // with a single channel every result closes its frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (cfg_q.chans == 4'd0 || cfg_q.chans == 4'd1)) |-> last_channel_o)
    else $error("single-channel result not marked last");

  // a held result is not replaced before it is popped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(sample_word_o) && $stable(last_channel_o)))
    else $error("result changed while stalled");

endmodule

`default_nettype wire

>>> rtl/stsg_front.sv
// Front end of the sine tone sample generator: takes tick transactions into a
// two-entry queue and classifies them for the back end. Depends on stsg_pkg.
`default_nettype none

module stsg_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push,
  output logic               full,
  input  wire logic          restart_i,
  input  wire logic          silent_i,
  output stsg_pkg::tick_t    tick_o,
  input  wire logic          take_i
);

  stsg_pkg::tick_e mem_q [2];
  logic            wr_ptr_q, wr_ptr_d;
  logic            rd_ptr_q, rd_ptr_d;
  logic [1:0]      count_q, count_d;
  logic            wr_en, rd_en;

  assign full  = (count_q == 2'd2);
  assign wr_en = push && !full;
  assign rd_en = take_i && (count_q != 2'd0);

  assign tick_o.valid = (count_q != 2'd0);
  assign tick_o.kind  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ wr_en;
    rd_ptr_d = rd_ptr_q ^ rd_en;
    count_d  = count_q + {1'b0, wr_en} - {1'b0, rd_en};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= stsg_pkg::tick_e'({silent_i, restart_i});
    end
  end

endmodule

`default_nettype wire

>>> rtl/stsg_back.sv
// Back end of the sine tone sample generator: phase by a shared bit-serial
// divider, sine lookup, formatting and per-channel output register.
// Depends on stsg_pkg.
`default_nettype none

module stsg_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire stsg_pkg::cfg_t                cfg_i,
  input  wire stsg_pkg::tick_t               tick_i,
  output logic                               take_o,
  output logic                               empty,
  input  wire logic                          pop,
  output logic [stsg_pkg::WORD_W-1:0]        sample_word_o,
  output logic                               last_channel_o
);

  localparam int RW = stsg_pkg::RATE_W;
  localparam int PW = stsg_pkg::PROD_W;
  localparam int QB = stsg_pkg::QUARTER_BITS;
  localparam int SB = stsg_pkg::SINE_TABLE_BITS;
  localparam int CW = stsg_pkg::CNT_W;
  localparam int MW = stsg_pkg::MAG_W;
  localparam int WW = stsg_pkg::WORD_W;
  localparam int HW = stsg_pkg::CHCNT_W;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_MOD1 = 8'b0000_0010,
    ST_MUL  = 8'b0000_0100,
    ST_MOD2 = 8'b0000_1000,
    ST_DIV  = 8'b0001_0000,
    ST_LOOK = 8'b0010_0000,
    ST_FMT  = 8'b0100_0000,
    ST_EMIT = 8'b1000_0000
  } state_e;

  state_e          state_q, state_d;
  logic [RW-1:0]   idx_q, idx_d;
  logic [RW-1:0]   rem_q, rem_d;
  logic [PW-1:0]   div_q, div_d;
  logic [SB-1:0]   quot_q, quot_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [MW-1:0]   mag_q, mag_d;
  logic            neg_q, neg_d;
  logic [WW-1:0]   word_q, word_d;
  logic [HW-1:0]   ch_q, ch_d;
  logic            out_valid_q, out_valid_d;
  logic [WW-1:0]   out_word_q, out_word_d;
  logic            out_last_q, out_last_d;

  logic [RW-1:0]   rate_eff;
  logic [RW:0]     trial;
  logic            ge;
  logic [RW:0]     diff;
  logic [RW:0]     pos_inc;
  logic [RW-1:0]   idx_work;
  logic [HW-1:0]   chans_eff;
  logic            restart, silent;

  // sine lookup
  logic [1:0]      quad;
  logic [QB-1:0]   frac;
  logic [QB-1:0]   lut_idx;
  logic [MW-1:0]   mag_look;

  // formatting
  logic [16:0]     level;
  logic [16:0]     mul_in;
  logic [15:0]     mul_k;
  logic [32:0]     fprod;
  logic [WW-1:0]   scaled;
  logic [WW-1:0]   fword;

  logic            slot_free;

  assign rate_eff = (cfg_i.rate == '0) ? RW'(1) : cfg_i.rate;
  assign trial    = {rem_q, div_q[PW-1]};
  assign ge       = (trial >= {1'b0, rate_eff});
  assign diff     = trial - {1'b0, rate_eff};
  assign pos_inc  = {1'b0, rem_q} + (RW+1)'(1);

  assign restart  = tick_i.kind[0];
  assign silent   = tick_i.kind[1];
  assign idx_work = restart ? '0 : idx_q;

  always_comb begin
    if (cfg_i.chans == '0) begin
      chans_eff = HW'(1);
    end else if (32'(cfg_i.chans) > stsg_pkg::MAX_CHANNELS) begin
      chans_eff = HW'(stsg_pkg::MAX_CHANNELS);
    end else begin
      chans_eff = HW'(cfg_i.chans);
    end
  end

  assign quad    = quot_q[SB-1:SB-2];
  assign frac    = quot_q[QB-1:0];
  assign lut_idx = quad[0] ? (QB'(0) - frac) : frac;
  assign mag_look = (quad[0] && frac == '0) ? stsg_pkg::SINE_PEAK
                                             : stsg_pkg::SINE_LUT[lut_idx];

  always_comb begin
    level  = neg_q ? (17'd32768 - 17'(mag_q)) : (17'd32768 + 17'(mag_q));
    mul_in = cfg_i.unsig ? level : 17'(mag_q);
    if (cfg_i.unsig) begin
      mul_k = cfg_i.wide ? 16'd65535 : 16'd255;
    end else begin
      mul_k = cfg_i.wide ? 16'd32767 : 16'd127;
    end
    fprod  = 33'(mul_in) * 33'(mul_k);
    scaled = cfg_i.unsig ? fprod[31:16] : fprod[30:15];
    fword  = (neg_q && !cfg_i.unsig) ? (WW'(0) - scaled) : scaled;
    if (!cfg_i.wide) begin
      fword = {8'd0, fword[7:0]};
    end else if (cfg_i.big) begin
      fword = {fword[7:0], fword[15:8]};
    end
  end

  assign slot_free = !out_valid_q || pop;
  assign take_o    = (state_q == ST_IDLE);

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    rem_d       = rem_q;
    div_d       = div_q;
    quot_d      = quot_q;
    cnt_d       = cnt_q;
    mag_d       = mag_q;
    neg_d       = neg_q;
    word_d      = word_q;
    ch_d        = ch_q;
    out_valid_d = out_valid_q && !pop;
    out_word_d  = out_word_q;
    out_last_d  = out_last_q;

    unique case (state_q)
      ST_IDLE: begin
        if (tick_i.valid) begin
          idx_d = idx_work;
          if (silent) begin
            mag_d   = '0;
            neg_d   = 1'b0;
            state_d = ST_FMT;
          end else begin
            rem_d   = '0;
            div_d   = {idx_work, (PW-RW)'(0)};
            cnt_d   = CW'(RW);
            state_d = ST_MOD1;
          end
        end
      end
      ST_MOD1, ST_MOD2, ST_DIV: begin
        rem_d  = ge ? diff[RW-1:0] : trial[RW-1:0];
        div_d  = div_q << 1;
        quot_d = {quot_q[SB-2:0], ge};
        cnt_d  = cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          if (state_q == ST_MOD1) begin
            state_d = ST_MUL;
          end else if (state_q == ST_MOD2) begin
            div_d   = '0;
            cnt_d   = CW'(SB);
            state_d = ST_DIV;
          end else begin
            state_d = ST_LOOK;
          end
        end
      end
      ST_MUL: begin
        // remainder holds the wrapped index here
        idx_d   = (pos_inc >= {1'b0, rate_eff}) ? '0 : pos_inc[RW-1:0];
        div_d   = PW'(cfg_i.freq) * PW'(rem_q);
        rem_d   = '0;
        cnt_d   = CW'(PW);
        state_d = ST_MOD2;
      end
      ST_LOOK: begin
        mag_d   = mag_look;
        neg_d   = quad[1] && (mag_look != '0);
        state_d = ST_FMT;
      end
      ST_FMT: begin
        word_d  = fword;
        ch_d    = '0;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_word_d  = word_q;
          out_last_d  = (ch_q + HW'(1) == chans_eff);
          ch_d        = ch_q + HW'(1);
          if (ch_q + HW'(1) == chans_eff) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      cnt_q       <= '0;
      ch_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      ch_q        <= ch_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q      <= rem_d;
    div_q      <= div_d;
    quot_q     <= quot_d;
    mag_q      <= mag_d;
    neg_q      <= neg_d;
    word_q     <= word_d;
    out_word_q <= out_word_d;
    out_last_q <= out_last_d;
  end

  assign empty          = !out_valid_q;
  assign sample_word_o  = out_word_q;
  assign last_channel_o = out_last_q;

endmodule

`default_nettype wire
